>>> rtl/core/ncr_pkg.sv
// Shared constants, codes and types for the neighbour cache resolver.
package ncr_pkg;

	// table geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);

	// field widths
	localparam int ADDR_W    = 32;
	localparam int HW_W      = 48;
	localparam int CFG_IDX_W = 2;

	localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = {ADDR_W{1'b1}};
	localparam logic [HW_W-1:0]   HW_ALL_ONES   = {HW_W{1'b1}};

	// operation codes
	localparam logic OP_LEARN   = 1'b0;
	localparam logic OP_RESOLVE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_ADDRESS = 2'd2;

	// search token handed from cell to cell
	typedef struct packed {
		logic              active;
		logic              found;
		logic [ADDR_W-1:0] key;
		logic [HW_W-1:0]   hw;
	} token_t;

	// write word broadcast to every cell at the end of a learn
	typedef struct packed {
		logic              en;
		logic              found;
		logic [ADDR_W-1:0] proto;
		logic [HW_W-1:0]   hw;
	} wr_t;

endpackage

>>> rtl/core/ncr_cell.sv
// One table entry: holds a mapping, compares the passing token and hands it on.
module ncr_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ncr_pkg::token_t tok_in,
	output ncr_pkg::token_t tok_out,
	input  ncr_pkg::wr_t    wr,
	input  logic            sel,
	output logic            matched
);

	logic                       valid_q;
	logic [ncr_pkg::ADDR_W-1:0] proto_q;
	logic [ncr_pkg::HW_W-1:0]   hw_q;
	logic                       matched_q;
	logic                       active_q;
	logic                       found_q;
	logic [ncr_pkg::ADDR_W-1:0] key_q;
	logic [ncr_pkg::HW_W-1:0]   tok_hw_q;
	logic                       m;

	// entry compare against the token key
	assign m = valid_q && (proto_q == tok_in.key);

	// valid bit, match flag and token control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			matched_q <= 1'b0;
			active_q  <= 1'b0;
		end else begin
			active_q <= tok_in.active;
			if (tok_in.active) begin
				// first match only: an earlier cell already claimed it otherwise
				matched_q <= !tok_in.found && m;
			end
			if (wr.en && sel) begin
				valid_q <= 1'b1;
			end
		end
	end

	// entry contents and token payload
	always_ff @(posedge clk) begin
		found_q <= tok_in.found || m;
		key_q   <= tok_in.key;
		if (!tok_in.found && m) begin
			tok_hw_q <= hw_q;
		end else begin
			tok_hw_q <= tok_in.hw;
		end
		if (wr.en && sel) begin
			proto_q <= wr.proto;
			hw_q    <= wr.hw;
		end
	end

	assign tok_out.active = active_q;
	assign tok_out.found  = found_q;
	assign tok_out.key    = key_q;
	assign tok_out.hw     = tok_hw_q;
	assign matched        = matched_q;

endmodule

>>> rtl/core/ncr_chain.sv
// Row of table cells with the write select decode.
module ncr_chain (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ncr_pkg::token_t           tok_in,
	output ncr_pkg::token_t           tok_out,
	input  ncr_pkg::wr_t              wr,
	input  logic [ncr_pkg::IDX_W-1:0] ptr
);

	ncr_pkg::token_t                tok [ncr_pkg::ENTRIES+1];
	logic [ncr_pkg::ENTRIES-1:0]    matched;
	logic [ncr_pkg::ENTRIES-1:0]    sel;

	assign tok[0] = tok_in;

	for (genvar k = 0; k < ncr_pkg::ENTRIES; k++) begin : g_cell
		// update the matching entry, else replace the one at the pointer
		assign sel[k] = wr.found ? matched[k] : (ptr == ncr_pkg::IDX_W'(k));

		ncr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1]),
			.wr      (wr),
			.sel     (sel[k]),
			.matched (matched[k])
		);
	end

	assign tok_out = tok[ncr_pkg::ENTRIES];

endmodule

>>> rtl/core/neighbor_cache_resolver.sv
// Neighbour cache resolver top level: configuration, next-hop choice and sequencing.
// Table resolve or learn: a search token runs down the token chain; busy stays high until
// it leaves the last cell, taking no new item meanwhile; a resolve then strobes done.
// Broadcast resolve: done strobes the cycle after start, busy stays low. Learn of zero: no-op.
// Done is high for one cycle only; the receiver cannot stall.
// Reset clears config/result registers, valid bits and the replace pointer; no clearing pass.
module neighbor_cache_resolver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ncr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ncr_pkg::ADDR_W-1:0]    cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [ncr_pkg::ADDR_W-1:0]    proto_address,
	input  logic [ncr_pkg::HW_W-1:0]      hw_address,
	output logic                          done,
	output logic                          hit,
	output logic [ncr_pkg::HW_W-1:0]      found_hw_address,
	output logic [ncr_pkg::ADDR_W-1:0]    next_hop
);

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t                      state_q;
	logic [ncr_pkg::ADDR_W-1:0]  own_q;
	logic [ncr_pkg::ADDR_W-1:0]  mask_q;
	logic [ncr_pkg::ADDR_W-1:0]  gw_q;
	ncr_pkg::token_t             tok_q;
	ncr_pkg::token_t             last_tok;
	ncr_pkg::wr_t                wr;
	logic                        op_q;
	logic [ncr_pkg::HW_W-1:0]    hw_q;
	logic [ncr_pkg::IDX_W-1:0]   ptr_q;
	logic                        done_q;
	logic                        hit_q;
	logic [ncr_pkg::HW_W-1:0]    found_hw_q;
	logic [ncr_pkg::ADDR_W-1:0]  next_hop_q;

	logic                        accept;
	logic [ncr_pkg::ADDR_W-1:0]  directed;
	logic                        on_net;
	logic [ncr_pkg::ADDR_W-1:0]  target;
	logic                        is_bcast;
	logic                        search_end;

	assign busy   = (state_q == ST_SEARCH);
	assign accept = start && !busy;

	// broadcast check and next-hop choice
	assign directed = own_q | ~mask_q;
	assign on_net   = (proto_address & mask_q) == (own_q & mask_q);
	assign target   = on_net ? proto_address : gw_q;
	assign is_bcast = (proto_address == ncr_pkg::ADDR_ALL_ONES) || (proto_address == directed);

	assign search_end = busy && last_tok.active;

	// write word for the end of a learn
	assign wr.en    = search_end && (op_q == ncr_pkg::OP_LEARN);
	assign wr.found = last_tok.found;
	assign wr.proto = tok_q.key;
	assign wr.hw    = hw_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q  <= '0;
			mask_q <= '0;
			gw_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ncr_pkg::REG_OWN_ADDRESS:     own_q  <= cfg_data;
				ncr_pkg::REG_SUBNET_MASK:     mask_q <= cfg_data;
				ncr_pkg::REG_GATEWAY_ADDRESS: gw_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, pointer and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tok_q      <= '0;
			op_q       <= ncr_pkg::OP_LEARN;
			hw_q       <= '0;
			ptr_q      <= '0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			found_hw_q <= '0;
			next_hop_q <= '0;
		end else begin
			done_q       <= 1'b0;
			tok_q.active <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= operation;
						hw_q <= hw_address;
						if (operation == ncr_pkg::OP_RESOLVE && is_bcast) begin
							done_q     <= 1'b1;
							hit_q      <= 1'b1;
							found_hw_q <= ncr_pkg::HW_ALL_ONES;
							next_hop_q <= proto_address;
						end else if (operation == ncr_pkg::OP_RESOLVE ||
						             proto_address != '0) begin
							// launch a search token down the row
							tok_q.active <= 1'b1;
							tok_q.found  <= 1'b0;
							tok_q.hw     <= '0;
							tok_q.key    <= (operation == ncr_pkg::OP_RESOLVE) ?
							                target : proto_address;
							state_q      <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (last_tok.active) begin
						state_q <= ST_IDLE;
						if (op_q == ncr_pkg::OP_RESOLVE) begin
							done_q     <= 1'b1;
							hit_q      <= last_tok.found;
							found_hw_q <= last_tok.hw;
							next_hop_q <= last_tok.key;
						end else if (!last_tok.found) begin
							// new entry taken: advance round robin
							if (ptr_q == ncr_pkg::IDX_W'(ncr_pkg::ENTRIES - 1)) begin
								ptr_q <= '0;
							end else begin
								ptr_q <= ptr_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ncr_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_in  (tok_q),
		.tok_out (last_tok),
		.wr      (wr),
		.ptr     (ptr_q)
	);

	assign done             = done_q;
	assign hit              = hit_q;
	assign found_hw_address = found_hw_q;
	assign next_hop         = next_hop_q;

endmodule

>>> rtl/core/ncr_checker.sv
// Port-level checks for the neighbour cache resolver, bound to the top level.
module ncr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          operation,
	input logic [ncr_pkg::ADDR_W-1:0]    proto_address,
	input logic                          done,
	input logic                          hit,
	input logic [ncr_pkg::HW_W-1:0]      found_hw_address,
	input logic [ncr_pkg::ADDR_W-1:0]    next_hop
);

	// a result is only given once the search has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// a miss carries a zero hardware address
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (found_hw_address == '0))
		else $error("miss with non-zero hardware address");

	// a learn never gives a result on the following cycle
	a_learn_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == ncr_pkg::OP_LEARN) |=> !done)
		else $error("result after a learn");

	// limited broadcast answers at once with itself as next hop
	a_bcast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == ncr_pkg::OP_RESOLVE &&
		 proto_address == ncr_pkg::ADDR_ALL_ONES)
		|=> (done && hit && found_hw_address == ncr_pkg::HW_ALL_ONES &&
		     next_hop == $past(proto_address)))
		else $error("broadcast resolve not answered at once");

	// busy only rises on an accepted word
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

endmodule

bind neighbor_cache_resolver ncr_checker u_ncr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.operation        (operation),
	.proto_address    (proto_address),
	.done             (done),
	.hit              (hit),
	.found_hw_address (found_hw_address),
	.next_hop         (next_hop)
);

>>> verif/neighbor_cache_resolver_tb.sv
// Self-checking testbench for the neighbour cache resolver: directed cases, then random traffic.
`timescale 1ns / 100ps

module neighbor_cache_resolver_tb;
	import ncr_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = ENTRIES + 6;
	localparam int POOL_SIZE = 24;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// one expected answer of a resolve
	typedef struct {
		logic              hit;
		logic [HW_W-1:0]   hw;
		logic [ADDR_W-1:0] hop;
	} answer_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	logic                 start;
	logic                 busy;
	logic                 operation;
	logic [ADDR_W-1:0]    proto_address;
	logic [HW_W-1:0]      hw_address;
	logic                 done;
	logic                 hit;
	logic [HW_W-1:0]      found_hw_address;
	logic [ADDR_W-1:0]    next_hop;

	neighbor_cache_resolver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.operation(operation),
		.proto_address(proto_address),
		.hw_address(hw_address),
		.done(done),
		.hit(hit),
		.found_hw_address(found_hw_address),
		.next_hop(next_hop)
	);

	// shadow copy of the cache and its registers
	logic              shadow_valid [ENTRIES];
	logic [ADDR_W-1:0] shadow_proto [ENTRIES];
	logic [HW_W-1:0]   shadow_hw    [ENTRIES];
	logic [IDX_W-1:0]  shadow_ptr;
	logic [ADDR_W-1:0] own_addr;
	logic [ADDR_W-1:0] net_mask;
	logic [ADDR_W-1:0] gw_addr;

	answer_t           pending_answers[$];
	answer_t           head_answer;
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	int error_count;
	int stall_cycles;
	int learn_count;
	int resolve_count;
	int hit_count;
	int bcast_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mismatch report: one line per fault
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("ERROR at %0t ns: %s got %0h expected %0h", $time, what, got, want);
	endtask

	// index of the valid entry holding addr, or -1
	function automatic int cache_lookup(input logic [ADDR_W-1:0] addr);
		for (int k = 0; k < ENTRIES; k++)
			if (shadow_valid[k] && shadow_proto[k] == addr)
				return k;
		return -1;
	endfunction

	// learn: address zero is ignored, else update in place or refill at the round-robin pointer
	task automatic learn_mapping(input logic [ADDR_W-1:0] addr, input logic [HW_W-1:0] hw);
		int k;
		k = cache_lookup(addr);
		if (addr == '0)
			return;
		if (k >= 0) begin
			shadow_hw[k] = hw;
		end else begin
			shadow_proto[shadow_ptr] = addr;
			shadow_hw[shadow_ptr]    = hw;
			shadow_valid[shadow_ptr] = 1'b1;
			shadow_ptr               = shadow_ptr + 1'b1;
		end
	endtask

	// resolve: broadcast check, next-hop choice, then table search
	function automatic answer_t resolve_answer(input logic [ADDR_W-1:0] dest);
		answer_t           a;
		logic [ADDR_W-1:0] directed;
		logic [ADDR_W-1:0] target;
		int                k;
		directed = own_addr | ~net_mask;
		if (dest == ADDR_ALL_ONES || dest == directed) begin
			a.hit = 1'b1;
			a.hw  = HW_ALL_ONES;
			a.hop = dest;
			return a;
		end
		target = ((dest & net_mask) == (own_addr & net_mask)) ? dest : gw_addr;
		k = cache_lookup(target);
		a.hit = (k >= 0);
		a.hw  = (k >= 0) ? shadow_hw[k] : '0;
		a.hop = target;
		return a;
	endfunction

	// offer one word and wait until it is taken
	task automatic send_word(input logic op, input logic [ADDR_W-1:0] addr,
			input logic [HW_W-1:0] hw);
		answer_t a;
		start         <= 1'b1;
		operation     <= op;
		proto_address <= addr;
		hw_address    <= hw;
		do @(posedge clk); while (busy);
		if (op == OP_LEARN) begin
			learn_count++;
			learn_mapping(addr, hw);
		end else begin
			a = resolve_answer(addr);
			resolve_count++;
			if (a.hit)
				hit_count++;
			if (addr == ADDR_ALL_ONES || addr == (own_addr | ~net_mask))
				bcast_count++;
			pending_answers.push_back(a);
		end
	endtask

	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// sender holds off until every outstanding answer is back
	task automatic drain_answers();
		start <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	// block idle: no answers due, not busy, and learns given time to finish
	task automatic settle_block();
		drain_answers();
		while (busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_OWN_ADDRESS:     own_addr = val;
			REG_SUBNET_MASK:     net_mask = val;
			REG_GATEWAY_ADDRESS: gw_addr  = val;
			default: ;
		endcase
	endtask

	// write all three registers, optionally the spare index too
	task automatic configure(input logic [ADDR_W-1:0] own, input logic [ADDR_W-1:0] mask,
			input logic [ADDR_W-1:0] gw, input bit poke_spare);
		settle_block();
		push_reg(REG_OWN_ADDRESS, own);
		push_reg(REG_SUBNET_MASK, mask);
		if (poke_spare)
			push_reg(REG_SPARE, 32'($urandom));
		push_reg(REG_GATEWAY_ADDRESS, gw);
		cfg_we <= 1'b0;
	endtask

	// registers at reset: mask zero puts everything on the subnet
	task automatic test_reset_defaults();
		send_word(OP_RESOLVE, 32'h0000_0000, '0);
		send_word(OP_RESOLVE, 32'h1234_5678, HW_ALL_ONES);
		send_word(OP_RESOLVE, ADDR_ALL_ONES, '0);
	endtask

	// learning, in-place update, hits and misses on and off the subnet
	task automatic test_learn_and_update();
		configure(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 1'b1);
		send_word(OP_LEARN, 32'h0000_0000, 48'h0000_0000_0123);
		send_word(OP_RESOLVE, 32'h0000_0000, '0);
		send_word(OP_LEARN, 32'hC0A8_0101, '0);
		send_word(OP_LEARN, 32'hC0A8_01FE, HW_ALL_ONES);
		send_word(OP_LEARN, 32'hC0A8_0102, 48'h0123_4567_89AB);
		send_word(OP_LEARN, 32'hC0A8_0102, 48'hFEDC_BA98_7654);
		send_word(OP_RESOLVE, 32'hC0A8_0102, '0);
		send_word(OP_RESOLVE, 32'hC0A8_0101, '0);
		send_word(OP_RESOLVE, 32'h0808_0808, '0);
		send_word(OP_RESOLVE, 32'hC0A8_01FE, '0);
		send_word(OP_RESOLVE, 32'hC0A8_0133, '0);
	endtask

	// limited and directed broadcast answer at once, even if learned
	task automatic test_broadcast();
		send_word(OP_RESOLVE, ADDR_ALL_ONES, '0);
		send_word(OP_RESOLVE, 32'hC0A8_01FF, '0);
		send_word(OP_LEARN, ADDR_ALL_ONES, 48'h0000_0000_0005);
		send_word(OP_RESOLVE, ADDR_ALL_ONES, '0);
	endtask

	// gateway zero, and a full mask where own address is the directed broadcast
	task automatic test_gateway_zero();
		configure(32'h0A01_0203, 32'hFFFF_0000, 32'h0000_0000, 1'b0);
		send_word(OP_RESOLVE, 32'h0B00_0001, '0);
		configure(32'h0A01_0203, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		send_word(OP_RESOLVE, 32'h0A01_0203, '0);
		send_word(OP_RESOLVE, 32'h0A01_0204, '0);
	endtask

	// random traffic under one setting, mostly on a small address pool
	task automatic random_phase(input logic [ADDR_W-1:0] own, input logic [ADDR_W-1:0] mask,
			input logic [ADDR_W-1:0] gw, input int n_items, input bit allow_idle);
		logic [ADDR_W-1:0] addr;
		logic [HW_W-1:0]   hw;
		logic              op;
		int                pick;
		bit                bursty;
		configure(own, mask, gw, 1'b0);
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = (i < POOL_SIZE * 2 / 3) ?
				((own & mask) | (32'($urandom) & ~mask)) : 32'($urandom);
		if (gw != '0)
			addr_pool[0] = gw;
		bursty = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			hw   = {16'($urandom), 32'($urandom)};
			pick = $urandom_range(0, 99);
			op   = OP_RESOLVE;
			addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (pick < 35) begin
				op = OP_LEARN;
				if (pick < 3)
					hw = HW_ALL_ONES;
				else if (pick < 6)
					hw = '0;
			end else if (pick < 70) begin
				op = OP_RESOLVE;
			end else if (pick < 80) begin
				addr = 32'($urandom);
			end else if (pick < 84) begin
				addr = pick[0] ? ADDR_ALL_ONES : (own | ~mask);
			end else if (pick < 88) begin
				op   = pick[0] ? OP_RESOLVE : OP_LEARN;
				addr = '0;
			end else begin
				op   = 1'($urandom);
				addr = 32'($urandom);
			end
			send_word(op, addr, hw);
			if (i % 25 == 0)
				bursty = $urandom_range(0, 1);
			if ($urandom_range(0, 49) == 0)
				drain_answers();
			else if (allow_idle && bursty && $urandom_range(0, 2) == 0)
				idle_for($urandom_range(1, 18));
		end
	endtask

	task automatic test_random_traffic();
		random_phase(32'h0A00_0005, 32'hFFFF_FF00, 32'h0A00_0001, 100, 1'b1);
		random_phase(32'hC0A8_0164, 32'hFFFF_0000, 32'h0000_0000, 100, 1'b1);
		random_phase(32'($urandom), 32'hFFFF_FFFF, 32'($urandom), 100, 1'b1);
		random_phase(32'($urandom), 32'h0000_0000, 32'($urandom), 100, 1'b1);
		random_phase(32'($urandom), ~(32'hFFFF_FFFF >> $urandom_range(20, 30)),
			32'($urandom), 100, 1'b0);
	endtask

	// answer checker: every strobe must match the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected answer, next_hop", 64'(next_hop), '0);
			end else begin
				head_answer = pending_answers.pop_front();
				if (hit !== head_answer.hit)
					report_mismatch("hit", 64'(hit), 64'(head_answer.hit));
				if (found_hw_address !== head_answer.hw)
					report_mismatch("found_hw_address", 64'(found_hw_address),
						64'(head_answer.hw));
				if (next_hop !== head_answer.hop)
					report_mismatch("next_hop", 64'(next_hop), 64'(head_answer.hop));
			end
		end
	end

	// watchdog: too long with no word taken and no answer
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no progress for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_OWN_ADDRESS;
		cfg_data      = '0;
		start         = 1'b0;
		operation     = OP_LEARN;
		proto_address = '0;
		hw_address    = '0;
		error_count   = 0;
		stall_cycles  = 0;
		learn_count   = 0;
		resolve_count = 0;
		hit_count     = 0;
		bcast_count   = 0;
		own_addr      = '0;
		net_mask      = '0;
		gw_addr       = '0;
		shadow_ptr    = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			shadow_valid[k] = 1'b0;
			shadow_proto[k] = '0;
			shadow_hw[k]    = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_learn_and_update();
		test_broadcast();
		test_gateway_zero();
		test_random_traffic();

		// wind down: wait for the last answers, then a little longer
		drain_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0)
			report_mismatch("answers never arrived", 64'(pending_answers.size()), '0);
		$display("Covered %0d learns and %0d resolves over nine register settings,",
			learn_count, resolve_count);
		$display("with %0d hits, %0d of them broadcast answers.", hit_count, bcast_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
rtl/core/ncr_pkg.sv
rtl/core/ncr_cell.sv
rtl/core/ncr_chain.sv
rtl/core/neighbor_cache_resolver.sv
rtl/core/ncr_checker.sv
verif/neighbor_cache_resolver_tb.sv
